/* src/tmis_pkg.sv */
package tmis_pkg;

    localparam int DATA_W    = 8;
    localparam int MEM_DEPTH = 256;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int REG_DEPTH = 16;
    localparam int REG_AW    = $clog2(REG_DEPTH);

    typedef enum logic [1:0] {
        CMD_WRITE   = 2'd0,
        CMD_READ    = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_EXEC    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RDW,
        ST_F1,
        ST_F2,
        ST_X1,
        ST_X2,
        ST_FIN
    } state_t;

    localparam logic [3:0] OP_LOAD_MEM = 4'h1;
    localparam logic [3:0] OP_LOAD_IMM = 4'h2;
    localparam logic [3:0] OP_STORE    = 4'h3;
    localparam logic [3:0] OP_MOVE     = 4'h4;
    localparam logic [3:0] OP_ADD      = 4'h5;
    localparam logic [3:0] OP_OR       = 4'h7;
    localparam logic [3:0] OP_AND      = 4'h8;
    localparam logic [3:0] OP_XOR      = 4'h9;
    localparam logic [3:0] OP_ROTATE   = 4'hA;
    localparam logic [3:0] OP_JUMP     = 4'hB;
    localparam logic [3:0] OP_HALT     = 4'hC;

    localparam logic [MEM_AW-1:0] LAST_PC = 8'hFE;
    localparam logic [REG_AW-1:0] REG_ZERO = 4'h0;

    function automatic logic [DATA_W-1:0] rot_right(input logic [DATA_W-1:0] v,
                                                    input logic [2:0] n);
        logic [2*DATA_W-1:0] both;
        both = {v, v} >> n;
        return both[DATA_W-1:0];
    endfunction

endpackage

/* src/tmis_cmd_if.sv */
interface tmis_cmd_if;
    import tmis_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic [MEM_AW-1:0] address;
    logic [DATA_W-1:0] write_data;

    modport source (output valid, output opcode, output address, output write_data,
                    input ready);
    modport sink   (input valid, input opcode, input address, input write_data,
                    output ready);
endinterface

/* src/tmis_rsp_if.sv */
interface tmis_rsp_if;
    import tmis_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic [MEM_AW-1:0] program_counter;
    logic              halted;

    modport source (output valid, output read_data, output program_counter,
                    output halted, input ready);
    modport sink   (input valid, input read_data, input program_counter,
                    input halted, output ready);
endinterface

/* src/tmis_ram.sv */
module tmis_ram #(
    parameter int WIDTH = tmis_pkg::DATA_W,
    parameter int DEPTH = tmis_pkg::MEM_DEPTH
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

/* src/teaching_machine_instruction_step_top.sv */
// Teaching machine with a 256-byte memory, sixteen 8-bit registers, a program
// counter and a halt flag, driven one request at a time.
// The cmd channel carries opcode (write byte, read byte, restart, execute one
// instruction), address and write_data. Every request gives exactly one item
// on the result channel: read_data (the byte on a read, else zero), the
// program counter and the halt flag after the request.
// Requests are handled one at a time by a sequencer around two synchronous
// memories with registered read data, one for main memory and one for the registers.
// Write, restart and execute while halted go straight to ST_FIN; read passes
// ST_RDW; execute fetches the instruction bytes in ST_F1 and ST_F2, then goes
// to ST_FIN (load immediate, halt, no-op), through ST_X1 (one register or memory
// operand) or through ST_X1 and ST_X2 (two register operands). A memory port is
// read once per fetch byte and once per operand; the next request is taken in
// the cycle after its predecessor's result is loaded.
// A result waiting on a stalled receiver does not block acceptance; the
// sequencer waits only when it must load a new result into the occupied slot.
// Reset clears the counter, the halt flag and per-entry valid bits for both
// memories, so every byte and register reads as zero until written; there is
// no clearing pass. Restart clears counter, halt flag and register valid bits, not memory ones.
module teaching_machine_instruction_step_top (
    input logic       clk,
    input logic       rst_n,
    tmis_cmd_if.sink  cmd,
    tmis_rsp_if.source result
);
    import tmis_pkg::*;

    state_t state_reg, state_next;
    logic [MEM_AW-1:0] pc_reg, pc_next;
    logic              halt_reg, halt_next;
    logic [DATA_W-1:0] b0_reg, b0_next;
    logic [DATA_W-1:0] b1_reg, b1_next;
    logic [DATA_W-1:0] a_reg, a_next;
    logic [DATA_W-1:0] res_reg, res_next;

    logic [MEM_DEPTH-1:0] mem_valid_reg;
    logic [REG_DEPTH-1:0] reg_valid_reg;
    logic                 mem_rv_reg;
    logic                 reg_rv_reg;

    logic              out_valid_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic [MEM_AW-1:0] out_pc_reg;
    logic              out_halt_reg;

    logic              mem_we, mem_re;
    logic [MEM_AW-1:0] mem_waddr, mem_raddr;
    logic [DATA_W-1:0] mem_wdata, mem_rdata, mem_data;
    logic              reg_we, reg_re, reg_clr;
    logic [REG_AW-1:0] reg_waddr, reg_raddr;
    logic [DATA_W-1:0] reg_wdata, reg_rdata, reg_data;

    logic              cmd_acc;
    logic              out_load;
    logic [3:0]        op;
    logic [REG_AW-1:0] r_idx;
    logic [MEM_AW-1:0] pc_adv;
    logic              halt_adv;

    tmis_ram #(.WIDTH(DATA_W), .DEPTH(MEM_DEPTH)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    tmis_ram #(.WIDTH(DATA_W), .DEPTH(REG_DEPTH)) u_regs (
        .clk   (clk),
        .we    (reg_we),
        .waddr (reg_waddr),
        .wdata (reg_wdata),
        .re    (reg_re),
        .raddr (reg_raddr),
        .rdata (reg_rdata)
    );

    // Entries never written since reset (or restart, for registers) read as zero.
    assign mem_data = mem_rv_reg ? mem_rdata : '0;
    assign reg_data = reg_rv_reg ? reg_rdata : '0;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_acc   = cmd.valid && cmd.ready;
    assign out_load  = (state_reg == ST_FIN) && (!out_valid_reg || result.ready);

    assign op       = b0_reg[7:4];
    assign r_idx    = b0_reg[3:0];
    assign pc_adv   = pc_reg + MEM_AW'(2);
    assign halt_adv = (pc_reg >= LAST_PC);

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        halt_next  = halt_reg;
        b0_next    = b0_reg;
        b1_next    = b1_reg;
        a_next     = a_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_waddr  = b1_reg;
        mem_wdata  = reg_data;
        mem_re     = 1'b0;
        mem_raddr  = pc_reg;
        reg_we     = 1'b0;
        reg_waddr  = r_idx;
        reg_wdata  = mem_data;
        reg_re     = 1'b0;
        reg_raddr  = r_idx;
        reg_clr    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_acc)
                begin
                    res_next = '0;
                    unique case (cmd_t'(cmd.opcode))
                        CMD_WRITE:
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = cmd.address;
                            mem_wdata  = cmd.write_data;
                            state_next = ST_FIN;
                        end
                        CMD_READ:
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = cmd.address;
                            state_next = ST_RDW;
                        end
                        CMD_RESTART:
                        begin
                            reg_clr    = 1'b1;
                            pc_next    = '0;
                            halt_next  = 1'b0;
                            state_next = ST_FIN;
                        end
                        CMD_EXEC:
                        begin
                            if (halt_reg)
                            begin
                                state_next = ST_FIN;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = pc_reg;
                                state_next = ST_F1;
                            end
                        end
                        default:
                        begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_RDW:
            begin
                res_next   = mem_data;
                state_next = ST_FIN;
            end
            ST_F1:
            begin
                b0_next    = mem_data;
                mem_re     = 1'b1;
                mem_raddr  = pc_reg + MEM_AW'(1);
                state_next = ST_F2;
            end
            ST_F2:
            begin
                b1_next    = mem_data;
                state_next = ST_X1;
                if (op == OP_HALT && mem_data == '0)
                begin
                    halt_next  = 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    unique case (op)
                        OP_LOAD_MEM:
                        begin
                            mem_re    = 1'b1;
                            mem_raddr = mem_data;
                        end
                        OP_LOAD_IMM:
                        begin
                            reg_we     = 1'b1;
                            reg_wdata  = mem_data;
                            pc_next    = pc_adv;
                            halt_next  = halt_adv;
                            state_next = ST_FIN;
                        end
                        OP_STORE, OP_ROTATE, OP_JUMP:
                        begin
                            reg_re = 1'b1;
                        end
                        OP_MOVE, OP_ADD, OP_OR, OP_AND, OP_XOR:
                        begin
                            reg_re    = 1'b1;
                            reg_raddr = mem_data[7:4];
                        end
                        default:
                        begin
                            pc_next    = pc_adv;
                            halt_next  = halt_adv;
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_X1:
            begin
                a_next     = reg_data;
                state_next = ST_FIN;
                unique case (op)
                    OP_LOAD_MEM:
                    begin
                        reg_we    = 1'b1;
                        reg_wdata = mem_data;
                        pc_next   = pc_adv;
                        halt_next = halt_adv;
                    end
                    OP_STORE:
                    begin
                        mem_we    = 1'b1;
                        pc_next   = pc_adv;
                        halt_next = halt_adv;
                    end
                    OP_MOVE:
                    begin
                        reg_we    = 1'b1;
                        reg_waddr = b1_reg[3:0];
                        reg_wdata = reg_data;
                        pc_next   = pc_adv;
                        halt_next = halt_adv;
                    end
                    OP_ROTATE:
                    begin
                        reg_we    = 1'b1;
                        reg_wdata = rot_right(reg_data, b1_reg[2:0]);
                        pc_next   = pc_adv;
                        halt_next = halt_adv;
                    end
                    OP_ADD, OP_OR, OP_AND, OP_XOR:
                    begin
                        reg_re     = 1'b1;
                        reg_raddr  = b1_reg[3:0];
                        state_next = ST_X2;
                    end
                    OP_JUMP:
                    begin
                        reg_re     = 1'b1;
                        reg_raddr  = REG_ZERO;
                        state_next = ST_X2;
                    end
                    default:
                    begin
                        state_next = ST_FIN;
                    end
                endcase
            end
            ST_X2:
            begin
                state_next = ST_FIN;
                pc_next    = pc_adv;
                halt_next  = halt_adv;
                unique case (op)
                    OP_ADD:
                    begin
                        reg_we    = 1'b1;
                        reg_wdata = a_reg + reg_data;
                    end
                    OP_OR:
                    begin
                        reg_we    = 1'b1;
                        reg_wdata = a_reg | reg_data;
                    end
                    OP_AND:
                    begin
                        reg_we    = 1'b1;
                        reg_wdata = a_reg & reg_data;
                    end
                    OP_XOR:
                    begin
                        reg_we    = 1'b1;
                        reg_wdata = a_reg ^ reg_data;
                    end
                    OP_JUMP:
                    begin
                        // A taken jump skips the end-of-memory check.
                        if (a_reg == reg_data)
                        begin
                            pc_next   = b1_reg;
                            halt_next = halt_reg;
                        end
                    end
                    default:
                    begin
                        pc_next   = pc_reg;
                        halt_next = halt_reg;
                    end
                endcase
            end
            ST_FIN:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            halt_reg      <= 1'b0;
            mem_valid_reg <= '0;
            reg_valid_reg <= '0;
            mem_rv_reg    <= 1'b0;
            reg_rv_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            halt_reg  <= halt_next;
            if (mem_we)
            begin
                mem_valid_reg[mem_waddr] <= 1'b1;
            end
            if (reg_clr)
            begin
                reg_valid_reg <= '0;
            end
            else if (reg_we)
            begin
                reg_valid_reg[reg_waddr] <= 1'b1;
            end
            if (mem_re)
            begin
                mem_rv_reg <= mem_valid_reg[mem_raddr];
            end
            if (reg_re)
            begin
                reg_rv_reg <= reg_valid_reg[reg_raddr];
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        b0_reg  <= b0_next;
        b1_reg  <= b1_next;
        a_reg   <= a_next;
        res_reg <= res_next;
        if (out_load)
        begin
            out_data_reg <= res_reg;
            out_pc_reg   <= pc_reg;
            out_halt_reg <= halt_reg;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.read_data       = out_data_reg;
    assign result.program_counter = out_pc_reg;
    assign result.halted          = out_halt_reg;

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_acc && cmd.opcode == CMD_RESTART |=> pc_reg == '0 && !halt_reg)
        else $error("restart did not clear counter and halt flag");

    a_halted_exec_stable: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_acc && cmd.opcode == CMD_EXEC && halt_reg |=> $stable(pc_reg) && halt_reg)
        else $error("execute while halted changed the machine");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg && !(cmd_acc && cmd.opcode == CMD_RESTART) |=> halt_reg)
        else $error("halt flag cleared without a restart");

    a_mem_single_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("main memory read and written in the same cycle");

endmodule

/* tb/sv/teaching_machine_instruction_step_top_tb.sv */
module teaching_machine_instruction_step_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tmis_pkg::*;

    localparam int DIRECTED_ROWS   = 24;
    localparam int RANDOM_REQUESTS = 1150;
    localparam int LONG_HOLD       = 400;
    localparam int SETTLE_CYCLES   = 20;
    localparam int CYCLE_LIMIT     = 1000000;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [MEM_AW-1:0] program_counter;
        logic              halted;
    } result_t;

    typedef struct {
        cmd_t              c;
        logic [MEM_AW-1:0] a;
        logic [DATA_W-1:0] d;
        bit                typed;
        result_t           want;
    } step_row_t;

    logic clk;
    logic rst_n;

    tmis_cmd_if cmd_bus ();
    tmis_rsp_if rsp_bus ();

    teaching_machine_instruction_step_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_bus),
        .result (rsp_bus)
    );

    // Machine state as the testbench sees it.
    logic [DATA_W-1:0] mem_model [MEM_DEPTH];
    logic [DATA_W-1:0] reg_model [REG_DEPTH];
    logic [MEM_AW-1:0] pc_model;
    logic              halt_model;

    result_t pending_results [$];
    int      mismatch_count = 0;
    int      results_seen   = 0;
    int      requests_sent  = 0;
    int      cycle_count    = 0;

    logic [3:0] common_ops [10] = '{OP_LOAD_MEM, OP_LOAD_IMM, OP_STORE, OP_MOVE, OP_ADD,
                                    OP_OR, OP_AND, OP_XOR, OP_ROTATE, OP_JUMP};

    // Directed program: extremes of memory, load immediate, a wrapping add, a rotate,
    // halt and execute while halted, restart, a taken jump to 255 whose fetch wraps
    // to address 0, and running off the end of memory.
    step_row_t directed_rows [DIRECTED_ROWS] = '{
        '{CMD_READ,    8'h00, 8'h00, 1'b1, {8'h00, 8'h00, 1'b0}},
        '{CMD_READ,    8'hFF, 8'h00, 1'b1, {8'h00, 8'h00, 1'b0}},
        '{CMD_WRITE,   8'hFF, 8'hFF, 1'b1, {8'h00, 8'h00, 1'b0}},
        '{CMD_READ,    8'hFF, 8'h00, 1'b1, {8'hFF, 8'h00, 1'b0}},
        '{CMD_WRITE,   8'h00, 8'h20, 1'b1, {8'h00, 8'h00, 1'b0}},
        '{CMD_WRITE,   8'h01, 8'hFF, 1'b1, {8'h00, 8'h00, 1'b0}},
        '{CMD_EXEC,    8'h00, 8'h00, 1'b1, {8'h00, 8'h02, 1'b0}},
        '{CMD_WRITE,   8'h02, 8'h51, 1'b1, {8'h00, 8'h02, 1'b0}},
        '{CMD_WRITE,   8'h03, 8'h00, 1'b1, {8'h00, 8'h02, 1'b0}},
        '{CMD_EXEC,    8'h00, 8'h00, 1'b0, '0},
        '{CMD_WRITE,   8'h04, 8'hA1, 1'b1, {8'h00, 8'h04, 1'b0}},
        '{CMD_WRITE,   8'h05, 8'h03, 1'b1, {8'h00, 8'h04, 1'b0}},
        '{CMD_EXEC,    8'h00, 8'h00, 1'b0, '0},
        '{CMD_WRITE,   8'h06, 8'hC0, 1'b1, {8'h00, 8'h06, 1'b0}},
        '{CMD_WRITE,   8'h07, 8'h00, 1'b1, {8'h00, 8'h06, 1'b0}},
        '{CMD_EXEC,    8'h00, 8'h00, 1'b1, {8'h00, 8'h06, 1'b1}},
        '{CMD_EXEC,    8'hFF, 8'hFF, 1'b1, {8'h00, 8'h06, 1'b1}},
        '{CMD_RESTART, 8'h00, 8'h00, 1'b1, {8'h00, 8'h00, 1'b0}},
        '{CMD_WRITE,   8'h00, 8'hB0, 1'b1, {8'h00, 8'h00, 1'b0}},
        '{CMD_WRITE,   8'h01, 8'hFF, 1'b1, {8'h00, 8'h00, 1'b0}},
        '{CMD_EXEC,    8'h00, 8'h00, 1'b1, {8'h00, 8'hFF, 1'b0}},
        '{CMD_EXEC,    8'h00, 8'h00, 1'b1, {8'h00, 8'h01, 1'b1}},
        '{CMD_RESTART, 8'hFF, 8'hFF, 1'b1, {8'h00, 8'h00, 1'b0}},
        '{CMD_READ,    8'hFF, 8'h00, 1'b1, {8'hFF, 8'h00, 1'b0}}
    };

    function automatic result_t machine_step(input cmd_t c, input logic [MEM_AW-1:0] a,
                                             input logic [DATA_W-1:0] d);
        result_t           r;
        logic [DATA_W-1:0] hi;
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] v;
        logic [3:0]        op;
        logic [3:0]        rn;
        r = '0;
        case (c)
            CMD_WRITE:   mem_model[a] = d;
            CMD_READ:    r.read_data = mem_model[a];
            CMD_RESTART:
            begin
                foreach (reg_model[i])
                    reg_model[i] = '0;
                pc_model   = '0;
                halt_model = 1'b0;
            end
            default:
            begin
                hi = mem_model[pc_model];
                lo = mem_model[MEM_AW'(pc_model + 1)];
                op = hi[7:4];
                rn = hi[3:0];
                if (!halt_model)
                begin
                    if (op == OP_HALT && lo == 8'h00)
                        halt_model = 1'b1;
                    else if (op == OP_JUMP && reg_model[rn] == reg_model[REG_ZERO])
                        pc_model = lo;
                    else
                    begin
                        case (op)
                            OP_LOAD_MEM: reg_model[rn] = mem_model[lo];
                            OP_LOAD_IMM: reg_model[rn] = lo;
                            OP_STORE:    mem_model[lo] = reg_model[rn];
                            OP_MOVE:     reg_model[lo[3:0]] = reg_model[lo[7:4]];
                            OP_ADD:      reg_model[rn] = reg_model[lo[7:4]] + reg_model[lo[3:0]];
                            OP_OR:       reg_model[rn] = reg_model[lo[7:4]] | reg_model[lo[3:0]];
                            OP_AND:      reg_model[rn] = reg_model[lo[7:4]] & reg_model[lo[3:0]];
                            OP_XOR:      reg_model[rn] = reg_model[lo[7:4]] ^ reg_model[lo[3:0]];
                            OP_ROTATE:
                            begin
                                if (lo[2:0] != 3'd0)
                                begin
                                    v = reg_model[rn];
                                    reg_model[rn] = (v >> lo[2:0]) | (v << (4'd8 - lo[2:0]));
                                end
                            end
                            default: ;
                        endcase
                        if (pc_model >= LAST_PC)
                            halt_model = 1'b1;
                        pc_model = pc_model + 8'd2;
                    end
                end
            end
        endcase
        r.program_counter = pc_model;
        r.halted          = halt_model;
        return r;
    endfunction

    // Mostly back to back, some short gaps, a few long ones; every so often a
    // stretch where neither side idles at all.
    function automatic int pick_gap();
        int r;
        if ((cycle_count % 3000) >= 2400)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("mismatch at result %0d: %s got %h, wanted %h", results_seen, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_request(input cmd_t c, input logic [MEM_AW-1:0] a,
                                input logic [DATA_W-1:0] d, input bit typed,
                                input result_t want);
        int      gap;
        result_t pred;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_bus.valid      <= 1'b1;
        cmd_bus.opcode     <= c;
        cmd_bus.address    <= a;
        cmd_bus.write_data <= d;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        pred = machine_step(c, a, d);
        pending_results.push_back(typed ? want : pred);
        requests_sent++;
    endtask

    task automatic check_result();
        result_t want;
        results_seen++;
        if (pending_results.size() == 0)
        begin
            report_mismatch("result with no request outstanding, pc", rsp_bus.program_counter,
                            '0);
            return;
        end
        want = pending_results.pop_front();
        if (rsp_bus.read_data !== want.read_data)
            report_mismatch("read_data", rsp_bus.read_data, want.read_data);
        if (rsp_bus.program_counter !== want.program_counter)
            report_mismatch("program_counter", rsp_bus.program_counter, want.program_counter);
        if (rsp_bus.halted !== want.halted)
            report_mismatch("halted", {7'd0, rsp_bus.halted}, {7'd0, want.halted});
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Result side: checks every accepted result and throttles ready, with a long
    // hold-off twice in the run so the block fills and stalls its request side.
    initial
    begin
        int hold;
        int next_long_mark;
        int g;
        hold           = 0;
        next_long_mark = 300;
        rsp_bus.ready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_bus.valid && rsp_bus.ready)
                check_result();
            if (results_seen >= next_long_mark)
            begin
                hold           = LONG_HOLD;
                next_long_mark = next_long_mark + 500;
            end
            if (hold > 0)
            begin
                hold--;
                rsp_bus.ready <= 1'b0;
            end
            else
            begin
                g = pick_gap();
                if (g > 0)
                begin
                    hold = g - 1;
                    rsp_bus.ready <= 1'b0;
                end
                else
                    rsp_bus.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        logic [MEM_AW-1:0] base;
        logic [DATA_W-1:0] xy;
        logic [3:0]        op;
        logic [15:0]       word;
        int                pick;
        int                length;
        int                runs;
        bit                drained_once;

        drained_once       = 1'b0;
        rst_n              = 1'b0;
        cmd_bus.valid      = 1'b0;
        cmd_bus.opcode     = CMD_READ;
        cmd_bus.address    = '0;
        cmd_bus.write_data = '0;
        foreach (mem_model[i])
            mem_model[i] = '0;
        foreach (reg_model[i])
            reg_model[i] = '0;
        pc_model   = '0;
        halt_model = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].c, directed_rows[i].a, directed_rows[i].d,
                         directed_rows[i].typed, directed_rows[i].want);

        while (requests_sent < DIRECTED_ROWS + RANDOM_REQUESTS)
        begin
            if (!drained_once && requests_sent >= DIRECTED_ROWS + RANDOM_REQUESTS / 2)
            begin
                // Hold requests back until every outstanding one has answered.
                cmd_bus.valid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
                drained_once = 1'b1;
            end
            if ($urandom_range(0, 99) < 15)
                send_request(cmd_t'($urandom_range(0, 3)), MEM_AW'($urandom),
                             DATA_W'($urandom), 1'b0, '0);
            else
            begin
                // A short program: optional restart, a jump from address 0 to the program
                // when it starts elsewhere, the program, then execute requests with some reads.
                pick = $urandom_range(0, 99);
                if (pick < 15)
                    base = MEM_AW'($urandom_range(8'hF0, 8'hFF));
                else if (pick < 30)
                    base = '0;
                else
                    base = MEM_AW'($urandom);
                length = $urandom_range(2, 8);
                if ($urandom_range(0, 3) != 0)
                    send_request(CMD_RESTART, MEM_AW'($urandom), DATA_W'($urandom), 1'b0, '0);
                if (base != '0)
                begin
                    send_request(CMD_WRITE, 8'h00, {OP_JUMP, REG_ZERO}, 1'b0, '0);
                    send_request(CMD_WRITE, 8'h01, base, 1'b0, '0);
                end
                for (int i = 0; i < length; i++)
                begin
                    pick = $urandom_range(0, 99);
                    xy   = DATA_W'($urandom);
                    if (pick < 10)
                        op = 4'($urandom);
                    else if (pick < 16)
                    begin
                        op = OP_HALT;
                        xy = 8'h00;
                    end
                    else
                        op = common_ops[$urandom_range(0, 9)];
                    if (op == OP_LOAD_IMM && $urandom_range(0, 3) == 0)
                        xy = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    if (op == OP_JUMP && $urandom_range(0, 99) < 60)
                        xy = MEM_AW'(base + 2 * $urandom_range(0, length - 1));
                    word = {op, 4'($urandom), xy};
                    send_request(CMD_WRITE, MEM_AW'(base + 2 * i), word[15:8], 1'b0, '0);
                    send_request(CMD_WRITE, MEM_AW'(base + 2 * i + 1), word[7:0], 1'b0, '0);
                end
                runs = length + $urandom_range(0, 4);
                for (int i = 0; i < runs; i++)
                begin
                    send_request(CMD_EXEC, MEM_AW'($urandom), DATA_W'($urandom), 1'b0, '0);
                    if ($urandom_range(0, 99) < 15)
                        send_request(CMD_READ, MEM_AW'(base + $urandom_range(0, 15)),
                                     DATA_W'($urandom), 1'b0, '0);
                end
            end
        end
        cmd_bus.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
